// ===== rtl/kpc_pkg.sv =====
// Shared widths, constants and types of the keypad press classifier.
package kpc_pkg;

	localparam int ROW_W = 2;
	localparam int COL_W = 4;
	localparam int CNT_W = 8;

	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t HOLD_LOCKED = 8'hFF;
	localparam cnt_t LIMIT_RESET = 8'd50;

	typedef struct packed {
		logic short_evt;
		logic long_evt;
	} kpc_lane_evt_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_number;
		logic [COL_W-1:0] short_mask;
		logic [COL_W-1:0] long_mask;
	} kpc_result_t;

endpackage

// ===== rtl/kpc_in_if.sv =====
// Row sample channel: valid/ready handshake with row index and column levels.
interface kpc_in_if;
	logic                     valid;
	logic                     ready;
	logic [kpc_pkg::ROW_W-1:0] row_index;
	logic [kpc_pkg::COL_W-1:0] column_levels;

	modport source (output valid, output row_index, output column_levels, input ready);
	modport sink (input valid, input row_index, input column_levels, output ready);
endinterface

// ===== rtl/kpc_out_if.sv =====
// Event channel: valid/ready handshake with row number and short/long event masks.
interface kpc_out_if;
	logic                     valid;
	logic                     ready;
	logic [kpc_pkg::ROW_W-1:0] row_number;
	logic [kpc_pkg::COL_W-1:0] short_mask;
	logic [kpc_pkg::COL_W-1:0] long_mask;

	modport source (output valid, output row_number, output short_mask, output long_mask,
		input ready);
	modport sink (input valid, input row_number, input short_mask, input long_mask,
		output ready);
endinterface

// ===== rtl/keypad_press_classifier.sv =====
// Top level of the keypad press classifier: column lanes plus event merge.
//
// samples: one scanned keypad row per transaction, the row index and the
//   active-low column levels (bit low means the key is held).
// events: one transaction per sample, echoing the row with a short-press
//   mask (released before passing the long limit) and a long-press mask
//   (hold count just passed the limit).
// cfg_we/cfg_data: write long_press_limit; write only while the block is idle.
// Each column has its own lane with the hold counters of every row, so one
// row's columns update side by side in the cycle the sample is accepted.
// The result is registered in the output buffer when the sample is accepted.
// Throughput: one sample per cycle while samples.ready is high, set by the
//   combinational counter read-update-write in each lane.
// Stall: a two-entry output buffer keeps accepting while one result waits;
//   samples.ready drops only when both entries are full.
// Reset: all hold counters clear, the limit returns to 50, buffers empty.
module keypad_press_classifier #(
	parameter int ROW_COUNT    = 4,
	parameter int COLUMN_COUNT = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  kpc_pkg::cnt_t             cfg_data,
	kpc_in_if.sink                    samples,
	kpc_out_if.source                 events
);
	import kpc_pkg::*;

	localparam int LANES = (COLUMN_COUNT < COL_W) ? COLUMN_COUNT : COL_W;

	cnt_t          limit_q;
	logic          accept;
	logic          row_ok;
	kpc_lane_evt_t lane_evt [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	assign accept = samples.valid && samples.ready;
	assign row_ok = (32'(samples.row_index) < ROW_COUNT);

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		kpc_lane #(
			.ROWS(ROW_COUNT)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.accept    (accept),
			.active    (row_ok),
			.row_index (samples.row_index),
			.pressed   (!samples.column_levels[c]),
			.limit     (limit_q),
			.evt       (lane_evt[c])
		);
	end

	kpc_merge #(
		.LANES(LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.row_index (samples.row_index),
		.lane_evt  (lane_evt),
		.events    (events)
	);

endmodule

// ===== rtl/kpc_lane.sv =====
// One column lane: hold counters of every row for that column and press classification.
module kpc_lane #(
	parameter int ROWS = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      active,
	input  logic [kpc_pkg::ROW_W-1:0] row_index,
	input  logic                      pressed,
	input  kpc_pkg::cnt_t             limit,
	output kpc_pkg::kpc_lane_evt_t    evt
);
	import kpc_pkg::*;

	localparam int SEL_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	cnt_t          cnt_q [ROWS];
	logic [SEL_W-1:0] sel;
	cnt_t          cnt;
	cnt_t          cnt_inc;
	cnt_t          cnt_next;
	kpc_lane_evt_t evt_raw;

	assign sel     = SEL_W'(row_index);
	assign cnt     = active ? cnt_q[sel] : '0;
	assign cnt_inc = cnt + 1'b1;

	always_comb begin
		cnt_next = cnt;
		evt_raw  = '0;
		if (pressed) begin
			if (cnt != HOLD_LOCKED) begin
				if (cnt_inc > limit) begin
					evt_raw.long_evt = 1'b1;
					cnt_next         = HOLD_LOCKED;
				end else begin
					cnt_next = cnt_inc;
				end
			end
		end else if (cnt != '0) begin
			// a locked counter already reported its long press
			evt_raw.short_evt = (cnt != HOLD_LOCKED);
			cnt_next          = '0;
		end
	end

	assign evt = active ? evt_raw : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept && active) begin
			cnt_q[sel] <= cnt_next;
		end
	end

endmodule

// ===== rtl/kpc_merge.sv =====
// Merge lane events into row masks and hold them in a two-entry output buffer.
module kpc_merge #(
	parameter int LANES = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [kpc_pkg::ROW_W-1:0] row_index,
	input  kpc_pkg::kpc_lane_evt_t    lane_evt [LANES],
	kpc_out_if.source                 events
);
	import kpc_pkg::*;

	kpc_result_t res;
	kpc_result_t main_q;
	kpc_result_t skid_q;
	logic        main_vld_q;
	logic        skid_vld_q;
	logic        in_fire;
	logic        out_fire;

	always_comb begin
		res            = '0;
		res.row_number = row_index;
		for (int c = 0; c < LANES; c++) begin
			res.short_mask[c] = lane_evt[c].short_evt;
			res.long_mask[c]  = lane_evt[c].long_evt;
		end
	end

	assign in_ready = !skid_vld_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = main_vld_q && events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				// drain the skid entry into the output slot once it frees
				if (out_fire) begin
					skid_vld_q <= 1'b0;
				end
			end else begin
				main_vld_q <= in_fire || (main_vld_q && !out_fire);
				if (in_fire && main_vld_q && !out_fire) begin
					skid_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q && out_fire) begin
			main_q <= skid_q;
		end else if (in_fire && (!main_vld_q || out_fire)) begin
			main_q <= res;
		end
		if (in_fire && main_vld_q && !out_fire) begin
			skid_q <= res;
		end
	end

	assign events.valid      = main_vld_q;
	assign events.row_number = main_q.row_number;
	assign events.short_mask = main_q.short_mask;
	assign events.long_mask  = main_q.long_mask;

endmodule
